>>> rtl/priority_work_stealing_task_queues_unit_macros.svh
// Assertion macros used by the task queue RTL.
`ifndef PRIORITY_WORK_STEALING_TASK_QUEUES_UNIT_MACROS_SVH
`define PRIORITY_WORK_STEALING_TASK_QUEUES_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on the clock edge, skipped while reset is asserted.
`define PWSTQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property on the clock edge, also during reset.
`define PWSTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PWSTQ_ASSERT(lbl, clk, rstn, prop, msg)
`define PWSTQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/pwstq_pkg.sv
// Constants and types of the priority work-stealing task queues.
`default_nettype none
package pwstq_pkg;

  localparam int NumWorkers    = 4;
  localparam int NumPriorities = 3;
  localparam int QueueDepth    = 16;
  localparam int TagBits       = 16;

  localparam int NumQueues  = NumWorkers * NumPriorities;
  localparam int StoreDepth = NumQueues * QueueDepth;
  localparam int PendCap    = StoreDepth;

  localparam int WorkerW = (NumWorkers > 1) ? $clog2(NumWorkers) : 1;
  localparam int PrioW   = (NumPriorities > 1) ? $clog2(NumPriorities) : 1;
  localparam int QueueW  = (NumQueues > 1) ? $clog2(NumQueues) : 1;
  localparam int SlotW   = $clog2(QueueDepth);
  localparam int FillW   = $clog2(QueueDepth + 1);
  localparam int AddrW   = $clog2(StoreDepth);
  localparam int PendW   = $clog2(PendCap + 1);

  // Fixed port widths.
  localparam int TagFieldW    = 16;
  localparam int PrioFieldW   = 2;
  localparam int WorkerFieldW = 2;
  localparam int StatusW      = 3;
  localparam int CountW       = 8;

  typedef enum logic [StatusW-1:0] {
    StEnqOk    = 3'd0,
    StStopping = 3'd1,
    StFull     = 3'd2,
    StPopped   = 3'd3,
    StEmpty    = 3'd4
  } status_e;

endpackage
`default_nettype wire

>>> rtl/priority_work_stealing_task_queues_unit.sv
// Top level of the priority work-stealing task queues.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | req_type, task_tag, task_priority,
//          |           |                      | worker_id
//  out     | source    | out_valid_o/out_stall_i | status, out_tag, out_priority,
//          |           |                      | source_worker, pending_count
//  cfg     | sink      | cfg_we_i             | cfg_wdata_i -> stop_accepting
//
// For an enqueue, a rejected enqueue and a pop that finds nothing, the word
// is decided and written to the output register at the accept edge.
// A found task passes the task memory's read register before the output register.
// Reset clears the queue heads, fill counts, round-robin pointer, pending count and
// the stop register; the task memory is not cleared and needs no clearing pass.
// A stalled output word holds; a new item is taken when no pop waits on the task memory
// and the output register is free or being drained in the same cycle.
`default_nettype none
`include "priority_work_stealing_task_queues_unit_macros.svh"
module priority_work_stealing_task_queues_unit
  import pwstq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    req_type_i,
  input  wire logic [TagFieldW-1:0]    task_tag_i,
  input  wire logic [PrioFieldW-1:0]   task_priority_i,
  input  wire logic [WorkerFieldW-1:0] worker_id_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [StatusW-1:0]           status_o,
  output logic [TagFieldW-1:0]         out_tag_o,
  output logic [PrioFieldW-1:0]        out_priority_o,
  output logic [WorkerFieldW-1:0]      source_worker_o,
  output logic [CountW-1:0]            pending_count_o
);

  // Control state.
  logic               stop_q;
  logic [WorkerW-1:0] next_q, next_d;
  logic [PendW-1:0]   pending_q, pending_d;
  logic [SlotW-1:0]   head_q [NumQueues];
  logic [FillW-1:0]   fill_q [NumQueues];
  logic               pop_pend_q;
  logic               out_valid_q;

  // Output payload and the fields held for a pop waiting on memory.
  status_e            out_status_q;
  logic [TagFieldW-1:0]    out_tag_q;
  logic [PrioFieldW-1:0]   out_prio_q;
  logic [WorkerFieldW-1:0] out_worker_q;
  logic [CountW-1:0]       out_count_q;
  logic [PrioW-1:0]        hold_prio_q;
  logic [WorkerW-1:0]      hold_worker_q;
  logic [PendW-1:0]        hold_count_q;

  logic out_free, acc, load_pop;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pop_pend_q || !out_free;
  assign acc        = in_valid_i && !in_stall_o;
  assign load_pop   = pop_pend_q && out_free;

  // Pop search: the named worker first, then the others in circular order; within a
  // worker, the lowest non-empty priority wins.
  logic [WorkerW-1:0] req_worker;
  logic               found;
  logic [QueueW-1:0]  pick_q;
  logic [WorkerW-1:0] pick_w;
  logic [PrioW-1:0]   pick_p;

  assign req_worker = WorkerW'(worker_id_i % NumWorkers);

  always_comb begin
    logic [WorkerW:0]   wsum;
    logic [WorkerW-1:0] ww;
    logic [QueueW-1:0]  qi;
    found  = 1'b0;
    pick_q = '0;
    pick_w = '0;
    pick_p = '0;
    for (int off = 0; off < NumWorkers; off++) begin
      wsum = (WorkerW+1)'(req_worker) + (WorkerW+1)'(off);
      if (wsum >= (WorkerW+1)'(NumWorkers)) begin
        wsum = wsum - (WorkerW+1)'(NumWorkers);
      end
      ww = wsum[WorkerW-1:0];
      for (int p = 0; p < NumPriorities; p++) begin
        qi = QueueW'(int'(ww) * NumPriorities + p);
        if (!found && (fill_q[qi] != '0)) begin
          found  = 1'b1;
          pick_q = qi;
          pick_w = ww;
          pick_p = PrioW'(p);
        end
      end
    end
  end

  // Enqueue target: round-robin worker, priority saturated to the last level.
  logic [PrioW-1:0]  enq_p;
  logic [QueueW-1:0] enq_q;

  always_comb begin
    if (int'(task_priority_i) >= NumPriorities) begin
      enq_p = PrioW'(NumPriorities - 1);
    end else begin
      enq_p = PrioW'(task_priority_i);
    end
    enq_q = QueueW'(int'(next_q) * NumPriorities + int'(enq_p));
  end

  // One queue is touched per item: read its head and fill once.
  logic [QueueW-1:0] sel_q;
  logic [SlotW-1:0]  sel_head, wr_slot, head_inc;
  logic [FillW-1:0]  sel_fill;
  logic [FillW:0]    slot_sum;
  logic [AddrW-1:0]  mem_addr;
  logic              enq_ok, enq_full, pop_hit;

  assign sel_q    = req_type_i ? pick_q : enq_q;
  assign sel_head = head_q[sel_q];
  assign sel_fill = fill_q[sel_q];

  always_comb begin
    slot_sum = (FillW+1)'(sel_head) + (FillW+1)'(sel_fill);
    if (slot_sum >= (FillW+1)'(QueueDepth)) begin
      slot_sum = slot_sum - (FillW+1)'(QueueDepth);
    end
    wr_slot = slot_sum[SlotW-1:0];
    if (sel_head == SlotW'(QueueDepth - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = sel_head + SlotW'(1);
    end
  end

  assign enq_ok   = !req_type_i && !stop_q && (sel_fill < FillW'(QueueDepth));
  assign enq_full = !req_type_i && !stop_q && (sel_fill >= FillW'(QueueDepth));
  assign pop_hit  = req_type_i && found;
  assign mem_addr = AddrW'(sel_q) * AddrW'(QueueDepth)
                  + AddrW'(req_type_i ? sel_head : wr_slot);

  always_comb begin
    next_d    = next_q;
    pending_d = pending_q;
    if (acc && !req_type_i && !stop_q) begin
      if (next_q == WorkerW'(NumWorkers - 1)) begin
        next_d = '0;
      end else begin
        next_d = next_q + WorkerW'(1);
      end
    end
    if (acc && enq_ok) begin
      pending_d = pending_q + PendW'(1);
    end else if (acc && pop_hit) begin
      pending_d = pending_q - PendW'(1);
    end
  end

  // Task store: write on enqueue, read on a pop that found a task.
  logic [TagBits-1:0] rd_tag;

  pwstq_ram #(
    .Width(TagBits),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (acc && enq_ok),
    .waddr_i(mem_addr),
    .wdata_i(TagBits'(task_tag_i)),
    .re_i   (acc && pop_hit),
    .raddr_i(mem_addr),
    .rdata_o(rd_tag)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q      <= 1'b0;
      next_q      <= '0;
      pending_q   <= '0;
      pop_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        stop_q <= cfg_wdata_i;
      end
      next_q    <= next_d;
      pending_q <= pending_d;
      if (acc && enq_ok) begin
        fill_q[sel_q] <= sel_fill + FillW'(1);
      end else if (acc && pop_hit) begin
        // Advance the head and drop the taken task from the count.
        head_q[sel_q] <= head_inc;
        fill_q[sel_q] <= sel_fill - FillW'(1);
      end
      if (acc && pop_hit) begin
        pop_pend_q <= 1'b1;
      end else if (load_pop) begin
        pop_pend_q <= 1'b0;
      end
      if ((acc && !pop_hit) || load_pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc && pop_hit) begin
      hold_prio_q   <= pick_p;
      hold_worker_q <= pick_w;
      hold_count_q  <= pending_d;
    end
    if (load_pop) begin
      out_status_q <= StPopped;
      out_tag_q    <= TagFieldW'(rd_tag);
      out_prio_q   <= PrioFieldW'(hold_prio_q);
      out_worker_q <= WorkerFieldW'(hold_worker_q);
      out_count_q  <= CountW'(hold_count_q);
    end else if (acc && !pop_hit) begin
      out_tag_q   <= '0;
      out_prio_q  <= '0;
      out_count_q <= CountW'(pending_d);
      if (req_type_i) begin
        out_status_q <= StEmpty;
        out_worker_q <= '0;
      end else if (stop_q) begin
        out_status_q <= StStopping;
        out_worker_q <= '0;
      end else begin
        out_status_q <= enq_full ? StFull : StEnqOk;
        out_worker_q <= WorkerFieldW'(next_q);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_tag_o       = out_tag_q;
  assign out_priority_o  = out_prio_q;
  assign source_worker_o = out_worker_q;
  assign pending_count_o = out_count_q;

  `PWSTQ_ASSERT(a_pop_blocks_input, clk_i, rst_ni, pop_pend_q |-> in_stall_o, "input taken during pop read")
  `PWSTQ_ASSERT(a_pending_stable, clk_i, rst_ni, !acc |=> $stable(pending_q), "pending count moved without an item")
  `PWSTQ_ASSERT(a_stop_holds_target, clk_i, rst_ni, (acc && !req_type_i && stop_q) |=> $stable(next_q), "target advanced while stopping")
  `PWSTQ_ASSERT(a_pending_cap, clk_i, rst_ni, pending_q <= PendW'(PendCap), "pending count beyond capacity")

endmodule
`default_nettype wire

>>> rtl/pwstq_ram.sv
// Generic simple dual-port RAM with a registered, enabled read.
`default_nettype none
module pwstq_ram #(
  parameter int Width = 16,
  parameter int Depth = 192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
